FILE: rtl/core/vrsa_pkg.sv
// Shared types and constants of the video register and scroll address block.
package vrsa_pkg;

	// Sprite memory size and scroll address width
	localparam int SPRITE_MEM_DEPTH = 256;
	localparam int SPRITE_AW        = $clog2(SPRITE_MEM_DEPTH);
	localparam int VADDR_W          = 15;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Scroll address constants
	localparam logic [4:0]  COARSE_MAX   = 5'h1F;
	localparam logic [4:0]  ROW_LAST     = 5'd29;
	localparam logic [4:0]  ROW_WRAP     = 5'd31;
	localparam logic [14:0] INC_ACROSS   = 15'd1;
	localparam logic [14:0] INC_DOWN     = 15'd32;
	localparam logic [14:0] FINE_Y_STEP  = 15'h1000;
	localparam logic [14:0] HORIZ_MASK   = 15'h041F;
	localparam logic [14:0] VERT_MASK    = 15'h7BE0;
	localparam logic [7:0]  OAM_BUSY_VAL = 8'hFF;

	// Request kinds
	typedef enum logic [2:0] {
		REQ_WRITE    = 3'd0,
		REQ_READ     = 3'd1,
		REQ_COARSE_X = 3'd2,
		REQ_Y_INC    = 3'd3,
		REQ_COPY_H   = 3'd4,
		REQ_COPY_V   = 3'd5,
		REQ_VBLANK   = 3'd6,
		REQ_PRECLEAR = 3'd7
	} req_t;

	// Register selects
	typedef enum logic [2:0] {
		REG_CTRL    = 3'd0,
		REG_MASK    = 3'd1,
		REG_STATUS  = 3'd2,
		REG_OAMADDR = 3'd3,
		REG_OAMDATA = 3'd4,
		REG_SCROLL  = 3'd5,
		REG_ADDR    = 3'd6,
		REG_DATA    = 3'd7
	} reg_t;

	// Classified operation carried from front to back
	typedef enum logic [4:0] {
		OP_WR_CTRL,
		OP_WR_MASK,
		OP_WR_STATUS,
		OP_WR_OAMADDR,
		OP_WR_OAMDATA,
		OP_WR_SCROLL,
		OP_WR_ADDR,
		OP_WR_DATA,
		OP_RD_STATUS,
		OP_RD_OAM,
		OP_RD_DATA,
		OP_RD_OPEN,
		OP_COARSE_X,
		OP_Y_INC,
		OP_COPY_H,
		OP_COPY_V,
		OP_VBLANK,
		OP_PRECLEAR
	} op_t;

	// How the returned byte and the open-bus latch are formed
	typedef enum logic [2:0] {
		RK_NONE,
		RK_WRITE,
		RK_STATUS,
		RK_OAM,
		RK_DATA,
		RK_OPEN
	} rd_kind_t;

	// Input word
	typedef struct packed {
		logic [2:0] req_type;
		logic [2:0] reg_sel;
		logic [7:0] wr_data;
		logic [7:0] vram_rdata;
		logic       oam_busy;
	} in_t;

	// Output word
	typedef struct packed {
		logic [7:0]  read_data;
		logic [14:0] vram_addr;
		logic        vram_read;
		logic        vram_write;
		logic [7:0]  vram_wdata;
		logic        nmi;
		logic [2:0]  fine_x;
		logic        bg_enable;
		logic        sprite_enable;
	} out_t;

	// Classified command: byte is the write data or the video read data
	typedef struct packed {
		op_t        op;
		logic [7:0] byte_val;
		logic       busy;
	} cmd_t;

endpackage

FILE: rtl/core/vrsa_front.sv
// Front stage: accepts input words and classifies them into commands.
module vrsa_front
	import vrsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	logic front_valid_q;
	cmd_t cmd_q;
	cmd_t cmd_dec;
	logic accept;

	// Classify the request and pick the byte the back end needs
	always_comb begin
		cmd_dec.busy     = in_data.oam_busy;
		cmd_dec.byte_val = in_data.wr_data;
		cmd_dec.op       = OP_PRECLEAR;
		case (in_data.req_type)
			REQ_WRITE: begin
				case (in_data.reg_sel)
					REG_CTRL:    cmd_dec.op = OP_WR_CTRL;
					REG_MASK:    cmd_dec.op = OP_WR_MASK;
					REG_STATUS:  cmd_dec.op = OP_WR_STATUS;
					REG_OAMADDR: cmd_dec.op = OP_WR_OAMADDR;
					REG_OAMDATA: cmd_dec.op = OP_WR_OAMDATA;
					REG_SCROLL:  cmd_dec.op = OP_WR_SCROLL;
					REG_ADDR:    cmd_dec.op = OP_WR_ADDR;
					default:     cmd_dec.op = OP_WR_DATA;
				endcase
			end
			REQ_READ: begin
				case (in_data.reg_sel)
					REG_STATUS:  cmd_dec.op = OP_RD_STATUS;
					REG_OAMDATA: cmd_dec.op = OP_RD_OAM;
					REG_DATA: begin
						cmd_dec.op       = OP_RD_DATA;
						cmd_dec.byte_val = in_data.vram_rdata;
					end
					default:     cmd_dec.op = OP_RD_OPEN;
				endcase
			end
			REQ_COARSE_X: cmd_dec.op = OP_COARSE_X;
			REQ_Y_INC:    cmd_dec.op = OP_Y_INC;
			REQ_COPY_H:   cmd_dec.op = OP_COPY_H;
			REQ_COPY_V:   cmd_dec.op = OP_COPY_V;
			REQ_VBLANK:   cmd_dec.op = OP_VBLANK;
			default:      cmd_dec.op = OP_PRECLEAR;
		endcase
	end

	// Take a new word whenever the stage is empty or the held command moves on
	assign in_ready  = !front_valid_q || cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = front_valid_q;
	assign cmd       = cmd_q;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (accept) begin
			front_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			front_valid_q <= 1'b0;
		end
	end

	// Load the classified command
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_dec;
		end
	end

endmodule

FILE: rtl/core/vrsa_queue.sv
// Short command queue between the front and back stages.
module vrsa_queue
	import vrsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/core/vrsa_back.sv
// Back end: register file, scroll address updates, sprite memory and output stage.
module vrsa_back
	import vrsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	// Architectural registers
	logic [7:0]         ctrl_q;
	logic [7:0]         mask_q;
	logic [2:0]         flags_q;
	logic [7:0]         open_bus_q;
	logic [14:0]        vaddr_q;
	logic [14:0]        taddr_q;
	logic [2:0]         fine_q;
	logic               toggle_q;
	logic [SPRITE_AW-1:0] spr_addr_q;

	// Sprite memory and its registered read data
	logic [7:0]         sprite_mem [SPRITE_MEM_DEPTH];
	logic [7:0]         mem_rdata_q;

	// Next values
	logic [7:0]         ctrl_d;
	logic [7:0]         mask_d;
	logic [2:0]         flags_d;
	logic [14:0]        vaddr_d;
	logic [14:0]        taddr_d;
	logic [2:0]         fine_d;
	logic               toggle_d;
	logic [SPRITE_AW-1:0] spr_addr_d;
	logic               vr_d;
	logic               vw_d;
	logic               nmi_d;
	rd_kind_t           kind_d;

	// Output stage
	logic               valid_s2;
	rd_kind_t           kind_s2;
	logic [7:0]         byte_s2;
	logic               busy_s2;
	logic [2:0]         flags_s2;
	logic [14:0]        addr_s2;
	logic               vr_s2;
	logic               vw_s2;
	logic               nmi_s2;
	logic [2:0]         fine_s2;
	logic               bg_s2;
	logic               spr_s2;

	logic               issue;
	logic               deliver;
	logic               bg;
	logic [14:0]        data_inc;
	logic [7:0]         rd_byte;

	// Y increment with the row 29 and row 31 wraps
	function automatic logic [14:0] y_step(input logic [14:0] v);
		logic [4:0] cy;
		logic       nt_y;
		begin
			cy   = v[9:5];
			nt_y = v[11];
			if (v[14:12] != 3'd7) begin
				y_step = v + FINE_Y_STEP;
			end else begin
				if (cy == ROW_LAST) begin
					cy   = '0;
					nt_y = ~nt_y;
				end else if (cy == ROW_WRAP) begin
					cy = '0;
				end else begin
					cy = cy + 5'd1;
				end
				y_step = {3'b000, nt_y, v[10], cy, v[4:0]};
			end
		end
	endfunction

	assign deliver   = valid_s2 && out_ready;
	assign cmd_ready = !valid_s2 || out_ready;
	assign issue     = cmd_valid && cmd_ready;
	assign bg        = mask_q[3];
	assign data_inc  = ctrl_q[2] ? INC_DOWN : INC_ACROSS;

	// Execute the head command against the register state
	always_comb begin
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		flags_d    = flags_q;
		vaddr_d    = vaddr_q;
		taddr_d    = taddr_q;
		fine_d     = fine_q;
		toggle_d   = toggle_q;
		spr_addr_d = spr_addr_q;
		vr_d       = 1'b0;
		vw_d       = 1'b0;
		nmi_d      = 1'b0;
		kind_d     = RK_NONE;
		case (cmd.op)
			OP_WR_CTRL: begin
				kind_d         = RK_WRITE;
				ctrl_d         = cmd.byte_val;
				taddr_d[11:10] = cmd.byte_val[1:0];
			end
			OP_WR_MASK: begin
				kind_d = RK_WRITE;
				mask_d = cmd.byte_val;
			end
			OP_WR_STATUS: kind_d = RK_WRITE;
			OP_WR_OAMADDR: begin
				kind_d     = RK_WRITE;
				spr_addr_d = cmd.byte_val[SPRITE_AW-1:0];
			end
			OP_WR_OAMDATA: begin
				kind_d     = RK_WRITE;
				spr_addr_d = spr_addr_q + 1'b1;
			end
			OP_WR_SCROLL: begin
				kind_d = RK_WRITE;
				if (!toggle_q) begin
					taddr_d[4:0] = cmd.byte_val[7:3];
					fine_d       = cmd.byte_val[2:0];
					toggle_d     = 1'b1;
				end else begin
					taddr_d[9:5]   = cmd.byte_val[7:3];
					taddr_d[14:12] = cmd.byte_val[2:0];
					toggle_d       = 1'b0;
				end
			end
			OP_WR_ADDR: begin
				kind_d = RK_WRITE;
				if (!toggle_q) begin
					taddr_d[14]   = 1'b0;
					taddr_d[13:8] = cmd.byte_val[5:0];
					toggle_d      = 1'b1;
				end else begin
					taddr_d[7:0] = cmd.byte_val;
					vaddr_d      = {taddr_q[14:8], cmd.byte_val};
					toggle_d     = 1'b0;
				end
			end
			OP_WR_DATA: begin
				kind_d  = RK_WRITE;
				vw_d    = 1'b1;
				vaddr_d = vaddr_q + data_inc;
			end
			OP_RD_STATUS: begin
				kind_d     = RK_STATUS;
				flags_d[2] = 1'b0;
				toggle_d   = 1'b0;
			end
			OP_RD_OAM:  kind_d = RK_OAM;
			OP_RD_DATA: begin
				kind_d  = RK_DATA;
				vr_d    = 1'b1;
				vaddr_d = vaddr_q + data_inc;
			end
			OP_RD_OPEN: kind_d = RK_OPEN;
			OP_COARSE_X: begin
				if (bg) begin
					if (vaddr_q[4:0] == COARSE_MAX) begin
						vaddr_d = {vaddr_q[14:11], ~vaddr_q[10], vaddr_q[9:5], 5'b00000};
					end else begin
						vaddr_d = vaddr_q + INC_ACROSS;
					end
				end
			end
			OP_Y_INC: begin
				if (bg) begin
					vaddr_d = y_step(vaddr_q);
				end
			end
			OP_COPY_H: begin
				if (bg) begin
					vaddr_d = (vaddr_q & VERT_MASK) | (taddr_q & HORIZ_MASK);
				end
			end
			OP_COPY_V: begin
				if (bg) begin
					vaddr_d = (vaddr_q & HORIZ_MASK) | (taddr_q & VERT_MASK);
				end
			end
			OP_VBLANK: begin
				flags_d[2] = 1'b1;
				nmi_d      = ctrl_q[7];
			end
			default: flags_d = '0;
		endcase
	end

	// Commit register state on issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= '0;
			mask_q     <= '0;
			flags_q    <= '0;
			vaddr_q    <= '0;
			taddr_q    <= '0;
			fine_q     <= '0;
			toggle_q   <= 1'b0;
			spr_addr_q <= '0;
		end else if (issue) begin
			ctrl_q     <= ctrl_d;
			mask_q     <= mask_d;
			flags_q    <= flags_d;
			vaddr_q    <= vaddr_d;
			taddr_q    <= taddr_d;
			fine_q     <= fine_d;
			toggle_q   <= toggle_d;
			spr_addr_q <= spr_addr_d;
		end
	end

	// Write and read the sprite memory; hold read data while the output stalls
	always_ff @(posedge clk) begin
		if (issue && cmd.op == OP_WR_OAMDATA) begin
			sprite_mem[spr_addr_q] <= cmd.byte_val;
		end
		if (issue) begin
			mem_rdata_q <= sprite_mem[spr_addr_q];
		end
	end

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s2 <= cmd_valid;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s2  <= kind_d;
			byte_s2  <= cmd.byte_val;
			busy_s2  <= cmd.busy;
			flags_s2 <= flags_q;
			addr_s2  <= vaddr_q;
			vr_s2    <= vr_d;
			vw_s2    <= vw_d;
			nmi_s2   <= nmi_d;
			fine_s2  <= fine_d;
			bg_s2    <= mask_d[3];
			spr_s2   <= mask_d[4];
		end
	end

	// Form the returned byte from the status flags, sprite data, video read byte or open-bus latch
	always_comb begin
		case (kind_s2)
			RK_STATUS: rd_byte = {flags_s2, open_bus_q[4:0]};
			RK_OAM:    rd_byte = busy_s2 ? OAM_BUSY_VAL : mem_rdata_q;
			RK_DATA:   rd_byte = byte_s2;
			RK_OPEN:   rd_byte = open_bus_q;
			default:   rd_byte = '0;
		endcase
	end

	// Update the open-bus latch as each register access leaves; render events leave it unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_bus_q <= '0;
		end else if (deliver) begin
			case (kind_s2)
				RK_NONE:  open_bus_q <= open_bus_q;
				RK_WRITE: open_bus_q <= byte_s2;
				default:  open_bus_q <= rd_byte;
			endcase
		end
	end

	assign out_valid              = valid_s2;
	assign out_data.read_data     = rd_byte;
	assign out_data.vram_addr     = addr_s2;
	assign out_data.vram_read     = vr_s2;
	assign out_data.vram_write    = vw_s2;
	assign out_data.vram_wdata    = vw_s2 ? byte_s2 : 8'h00;
	assign out_data.nmi           = nmi_s2;
	assign out_data.fine_x        = fine_s2;
	assign out_data.bg_enable     = bg_s2;
	assign out_data.sprite_enable = spr_s2;

`ifndef NO_ASSERTIONS
	// Never overwrite a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> $stable(addr_s2) && valid_s2)
		else $error("stalled output word changed");

	// NMI follows control bit 7 on vblank start
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && cmd.op == OP_VBLANK) |=> (nmi_s2 == $past(ctrl_q[7])) && flags_q[2])
		else $error("vblank nmi mismatch");

	// Status read clears vblank and the write toggle
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && cmd.op == OP_RD_STATUS) |=> !toggle_q && !flags_q[2])
		else $error("status read did not clear state");

	// Video memory read and write strobes are never both set
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(vr_s2 && vw_s2))
		else $error("read and write strobe together");
`endif

endmodule

FILE: rtl/core/video_register_and_scroll_address.sv
// Top level of the video register file and scroll address block.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one CPU access or one
//   render event per word (in_t). Output channel out_valid/out_ready/out_data
//   returns exactly one result word (out_t) per input word, in order.
//   A front stage classifies each word and passes it through a two-entry
//   queue to the back end, which updates the registers, accesses the sprite
//   memory and fills the output register.
//   Path: front register, queue entry, output register. Throughput: one
//   word per cycle while the receiver is ready, set by the back end, which
//   commits one command per cycle and reads the sprite memory once per cycle.
//   When the receiver stalls, the output word holds, the back end stops
//   issuing, the queue fills and then in_ready drops; words are never lost.
//   Reset clears the state registers, the open-bus latch and the queue. Sprite
//   memory is not cleared: read an entry only after writing it.
module video_register_and_scroll_address
	import vrsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic head_valid;
	logic head_ready;
	cmd_t head_cmd;

	// Accept and classify
	vrsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// Decouple front and back
	vrsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_cmd    (head_cmd)
	);

	// Execute and return results
	vrsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd_ready (head_ready),
		.cmd       (head_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: sim/register_file_checker.sv
// Checker for the video register block: predicts each result word and compares it with the output.
module register_file_checker
	import vrsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the register file
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic [2:0]  flags_q;
	logic [7:0]  bus_latch;
	logic [14:0] v_addr;
	logic [14:0] t_addr;
	logic [2:0]  fine_q;
	logic        toggle_q;
	logic [7:0]  oam_ptr;
	logic [7:0]  oam_mem [SPRITE_MEM_DEPTH];

	out_t expected_results[$];

	// Step the video address after a data access
	function automatic void step_video_addr();
		v_addr = v_addr + (ctrl_q[2] ? INC_DOWN : INC_ACROSS);
	endfunction

	// Apply one word to the shadow state and return the result it should give
	function automatic out_t next_register_result(in_t w);
		out_t       r;
		logic       bg;
		logic [4:0] cy;
		r = '0;
		r.vram_addr = v_addr;
		bg = mask_q[3];
		case (req_t'(w.req_type))
			REQ_WRITE: begin
				bus_latch = w.wr_data;
				case (reg_t'(w.reg_sel))
					REG_CTRL: begin
						ctrl_q = w.wr_data;
						t_addr[11:10] = w.wr_data[1:0];
					end
					REG_MASK: mask_q = w.wr_data;
					REG_OAMADDR: oam_ptr = w.wr_data;
					REG_OAMDATA: begin
						oam_mem[oam_ptr] = w.wr_data;
						oam_ptr = oam_ptr + 8'd1;
					end
					REG_SCROLL: begin
						if (!toggle_q) begin
							t_addr[4:0] = w.wr_data[7:3];
							fine_q = w.wr_data[2:0];
						end else begin
							t_addr[9:5] = w.wr_data[7:3];
							t_addr[14:12] = w.wr_data[2:0];
						end
						toggle_q = ~toggle_q;
					end
					REG_ADDR: begin
						if (!toggle_q) begin
							t_addr[13:8] = w.wr_data[5:0];
							t_addr[14] = 1'b0;
						end else begin
							t_addr[7:0] = w.wr_data;
							v_addr = t_addr;
						end
						toggle_q = ~toggle_q;
					end
					REG_DATA: begin
						r.vram_write = 1'b1;
						r.vram_wdata = w.wr_data;
						step_video_addr();
					end
					default: ;
				endcase
			end
			REQ_READ: begin
				case (reg_t'(w.reg_sel))
					REG_STATUS: begin
						bus_latch = {flags_q, bus_latch[4:0]};
						flags_q[2] = 1'b0;
						toggle_q = 1'b0;
					end
					REG_OAMDATA: bus_latch = w.oam_busy ? OAM_BUSY_VAL : oam_mem[oam_ptr];
					REG_DATA: begin
						bus_latch = w.vram_rdata;
						r.vram_read = 1'b1;
						step_video_addr();
					end
					default: ;
				endcase
				r.read_data = bus_latch;
			end
			REQ_COARSE_X: begin
				if (bg) begin
					if (v_addr[4:0] == COARSE_MAX) begin
						v_addr[4:0] = 5'd0;
						v_addr[10] = ~v_addr[10];
					end else begin
						v_addr = v_addr + 15'd1;
					end
				end
			end
			REQ_Y_INC: begin
				if (bg) begin
					if (v_addr[14:12] != 3'd7) begin
						v_addr = v_addr + FINE_Y_STEP;
					end else begin
						v_addr[14:12] = 3'd0;
						cy = v_addr[9:5];
						// Last visible row flips the vertical nametable, row 31 wraps without it
						if (cy == ROW_LAST) begin
							cy = 5'd0;
							v_addr[11] = ~v_addr[11];
						end else if (cy == ROW_WRAP) begin
							cy = 5'd0;
						end else begin
							cy = cy + 5'd1;
						end
						v_addr[9:5] = cy;
					end
				end
			end
			REQ_COPY_H: if (bg) v_addr = (v_addr & VERT_MASK) | (t_addr & HORIZ_MASK);
			REQ_COPY_V: if (bg) v_addr = (v_addr & HORIZ_MASK) | (t_addr & VERT_MASK);
			REQ_VBLANK: begin
				flags_q[2] = 1'b1;
				r.nmi = ctrl_q[7];
			end
			default: flags_q = 3'd0;
		endcase
		r.fine_x = fine_q;
		r.bg_enable = mask_q[3];
		r.sprite_enable = mask_q[4];
		return r;
	endfunction

	task automatic check_field(string name, logic [14:0] want, logic [14:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare results, then queue the prediction for an accepted word
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			ctrl_q = '0;
			mask_q = '0;
			flags_q = '0;
			bus_latch = '0;
			v_addr = '0;
			t_addr = '0;
			fine_q = '0;
			toggle_q = 1'b0;
			oam_ptr = '0;
			expected_results.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, out_data.read_data);
					check_field("vram_addr", want.vram_addr, out_data.vram_addr);
					check_field("vram_read", want.vram_read, out_data.vram_read);
					check_field("vram_write", want.vram_write, out_data.vram_write);
					check_field("vram_wdata", want.vram_wdata, out_data.vram_wdata);
					check_field("nmi", want.nmi, out_data.nmi);
					check_field("fine_x", want.fine_x, out_data.fine_x);
					check_field("bg_enable", want.bg_enable, out_data.bg_enable);
					check_field("sprite_enable", want.sprite_enable, out_data.sprite_enable);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(next_register_result(in_data));
			pending = expected_results.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// Top of the video register block testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vrsa_pkg::*;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	int   fail_count;
	int   pending;

	int         words_sent = 0;
	logic [7:0] oam_ptr    = '0;
	bit         oam_written [SPRITE_MEM_DEPTH];
	bit         calm       = 1'b0;
	bit         drained    = 1'b0;

	video_register_and_scroll_address dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	register_file_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#200_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 350 && cyc < 430)
				out_ready <= 1'b0;
			else if (cyc >= 550 && cyc < 850)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 18);
		end
	end

	// Build a word with random side fields
	function automatic in_t mk(req_t rt, logic [2:0] rsel, logic [7:0] d);
		in_t w;
		w.req_type = rt;
		w.reg_sel = rsel;
		w.wr_data = d;
		w.vram_rdata = 8'($urandom);
		w.oam_busy = ($urandom_range(3) == 0);
		return w;
	endfunction

	// Offer one word and hold it until accepted
	task automatic offer_word(in_t w);
		bit took;
		// Never read a sprite entry that was not written
		if (w.req_type == REQ_READ && w.reg_sel == REG_OAMDATA && !oam_written[oam_ptr])
			w.oam_busy = 1'b1;
		if (w.req_type == REQ_WRITE && w.reg_sel == REG_OAMADDR)
			oam_ptr = w.wr_data;
		if (w.req_type == REQ_WRITE && w.reg_sel == REG_OAMDATA) begin
			oam_written[oam_ptr] = 1'b1;
			oam_ptr = oam_ptr + 8'd1;
		end
		calm = (words_sent >= 250 && words_sent < 450);
		if (!calm) begin
			while ($urandom_range(99) < 18) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= w;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		words_sent++;
	endtask

	task automatic send(req_t rt, logic [2:0] rsel, logic [7:0] d);
		offer_word(mk(rt, rsel, d));
	endtask

	task automatic render_event(req_t rt);
		offer_word(mk(rt, 3'($urandom), 8'($urandom)));
	endtask

	// One random sequence: mostly well-formed register traffic, some noise
	task automatic random_sequence();
		int         kind;
		int         n;
		logic [7:0] a;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// Scroll pair after a toggle reset
			send(REQ_READ, REG_STATUS, 8'($urandom));
			send(REQ_WRITE, REG_SCROLL, 8'($urandom));
			send(REQ_WRITE, REG_SCROLL, 8'($urandom));
		end else if (kind < 35) begin
			// Address pair then a run of data accesses
			send(REQ_READ, REG_STATUS, 8'($urandom));
			send(REQ_WRITE, REG_ADDR, 8'($urandom));
			send(REQ_WRITE, REG_ADDR, 8'($urandom));
			n = $urandom_range(6, 1);
			repeat (n) begin
				if ($urandom_range(1))
					send(REQ_READ, REG_DATA, 8'($urandom));
				else
					send(REQ_WRITE, REG_DATA, 8'($urandom));
			end
		end else if (kind < 60) begin
			// One scanline of scroll updates
			n = $urandom_range(8, 1);
			repeat (n) render_event(REQ_COARSE_X);
			render_event(REQ_Y_INC);
			render_event(REQ_COPY_H);
			if ($urandom_range(4) == 0)
				render_event(REQ_COPY_V);
		end else if (kind < 70) begin
			// Fill sprite entries and read them back
			a = 8'($urandom);
			send(REQ_WRITE, REG_OAMADDR, a);
			n = $urandom_range(8, 1);
			repeat (n) send(REQ_WRITE, REG_OAMDATA, 8'($urandom));
			send(REQ_WRITE, REG_OAMADDR, a + 8'($urandom_range(n - 1)));
			n = $urandom_range(4, 1);
			repeat (n) send(REQ_READ, REG_OAMDATA, 8'($urandom));
		end else if (kind < 78) begin
			send(REQ_WRITE, REG_CTRL, 8'($urandom));
		end else if (kind < 84) begin
			// Keep background mostly on so render events move the address
			a = 8'($urandom);
			a[3] = ($urandom_range(4) != 0);
			send(REQ_WRITE, REG_MASK, a);
		end else if (kind < 92) begin
			render_event(REQ_VBLANK);
			send(REQ_READ, REG_STATUS, 8'($urandom));
			if ($urandom_range(1))
				render_event(REQ_PRECLEAR);
		end else begin
			n = $urandom_range(3, 1);
			repeat (n) offer_word(mk(req_t'($urandom_range(7)), 3'($urandom), 8'($urandom)));
		end
	endtask

	// Reset, directed cases, random traffic, drain and verdict
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(REQ_READ, REG_STATUS, 8'h00);        // reset values
		send(REQ_WRITE, REG_CTRL, 8'h83);         // nmi on, nametable 3, step 1
		send(REQ_WRITE, REG_MASK, 8'h18);         // background and sprites on
		send(REQ_WRITE, REG_SCROLL, 8'hFF);
		send(REQ_WRITE, REG_SCROLL, 8'hFF);
		render_event(REQ_COPY_H);
		render_event(REQ_COPY_V);                 // address now all ones
		send(REQ_WRITE, REG_DATA, 8'hA5);         // address wraps to zero
		render_event(REQ_COPY_H);
		render_event(REQ_COPY_V);
		render_event(REQ_COARSE_X);               // coarse X wraps into next nametable
		render_event(REQ_Y_INC);                  // row 31 wraps without nametable flip
		send(REQ_WRITE, REG_SCROLL, 8'h00);
		send(REQ_WRITE, REG_SCROLL, 8'hEF);       // fine Y 7, row 29
		render_event(REQ_COPY_V);
		render_event(REQ_Y_INC);                  // row 29 wraps and flips nametable
		render_event(REQ_VBLANK);                 // raises nmi
		send(REQ_READ, REG_STATUS, 8'h00);        // vblank seen and cleared
		send(REQ_WRITE, REG_CTRL, 8'h04);         // step 32, nmi off
		send(REQ_WRITE, REG_ADDR, 8'hFF);
		send(REQ_WRITE, REG_ADDR, 8'hFF);
		send(REQ_READ, REG_DATA, 8'h00);
		send(REQ_WRITE, REG_OAMADDR, 8'hFF);
		send(REQ_WRITE, REG_OAMDATA, 8'h5A);      // sprite address wraps
		send(REQ_WRITE, REG_OAMADDR, 8'hFF);
		send(REQ_READ, REG_OAMDATA, 8'h00);
		offer_word('{req_type: REQ_READ, reg_sel: REG_OAMDATA, wr_data: 8'h00,
			vram_rdata: 8'h00, oam_busy: 1'b1});
		send(REQ_READ, REG_MASK, 8'h00);          // write-only register reads the latch
		send(REQ_WRITE, REG_STATUS, 8'hC3);
		render_event(REQ_PRECLEAR);
		send(REQ_WRITE, REG_MASK, 8'h00);
		render_event(REQ_COARSE_X);               // no effect with background off

		while (words_sent < 740) begin
			// Pause the sender once until every result is back
			if (!drained && words_sent >= 470) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				@(posedge clk);
			end
			random_sequence();
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
